/* rtl/core/tmfs_pkg.sv */
package tmfs_pkg;

    localparam int RAW_W = 12;
    localparam int POS_W = 10;
    localparam int DIM_W = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    typedef enum logic [1:0] {
        OP_PEN_UP    = 2'd0,
        OP_X_SAMPLE  = 2'd1,
        OP_Y_SAMPLE  = 2'd2,
        OP_FRAME_END = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1,
        CFG_LOWER_BOUND   = 2'd2,
        CFG_UPPER_BOUND   = 2'd3
    } cfg_idx_t;

    typedef logic [RAW_W-1:0] raw_t;
    typedef logic [POS_W-1:0] pos_t;
    typedef logic [DIM_W-1:0] dim_t;

endpackage

/* rtl/core/tmfs_median.sv */
module tmfs_median #(
    parameter int COUNT = 5
) (
    input  logic [COUNT-1:0][tmfs_pkg::RAW_W-1:0] store,
    output tmfs_pkg::raw_t                         median
);

    localparam int RANK_W = $clog2(COUNT + 1);
    localparam logic [RANK_W-1:0] MID = RANK_W'(COUNT / 2);

    logic [RANK_W-1:0] rank [COUNT];

    // stable rank: ties ordered by position, so exactly one entry sits at MID
    always_comb
    begin
        median = '0;
        for (int i = 0; i < COUNT; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < COUNT; j++)
            begin
                if (j != i)
                begin
                    if ((store[j] < store[i]) || ((j < i) && (store[j] == store[i])))
                    begin
                        rank[i] = rank[i] + RANK_W'(1);
                    end
                end
            end
        end
        for (int i = 0; i < COUNT; i++)
        begin
            if (rank[i] == MID)
            begin
                median = store[i];
            end
        end
    end

endmodule

/* rtl/core/touch_median_filter_scaler_unit.sv */
// Touch median filter and scaler. X and Y converter samples (12 bits) are
// collected into two stores of SAMPLE_COUNT entries each; further samples of
// a channel in the same frame are dropped once its store is full. A frame-end
// transaction takes the median of each whole store, reports it as the raw
// median, and, when both medians lie strictly between lower_bound and
// upper_bound, scales X by screen_width/FULL_SCALE and (FULL_SCALE - Y) by
// screen_height/FULL_SCALE, saturating at 1023, and reports touched. A pen-up
// transaction reports not touched with the previous positions and medians.
// Sample transactions produce no result. One transaction is taken per cycle
// while in_stall is low (out_stall back-pressure can raise it). For a result,
// medians are captured at acceptance, the scaling multiply is registered, and
// the divide by FULL_SCALE is a reciprocal multiply in the output stage.
// Configuration is always ready and should be written only while idle.
module touch_median_filter_scaler_unit #(
    parameter int SAMPLE_COUNT = 5,
    parameter int FULL_SCALE   = 4095
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           opcode,
    input  logic [tmfs_pkg::RAW_W-1:0]           sample,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 touched,
    output logic [tmfs_pkg::POS_W-1:0]           x_pos,
    output logic [tmfs_pkg::POS_W-1:0]           y_pos,
    output logic [tmfs_pkg::RAW_W-1:0]           x_median,
    output logic [tmfs_pkg::RAW_W-1:0]           y_median,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tmfs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tmfs_pkg::RAW_W-1:0]           cfg_data
);

    localparam int FILL_W  = $clog2(SAMPLE_COUNT + 1);
    localparam int FS_W    = $clog2(FULL_SCALE + 1);
    localparam int VAL_W   = (FS_W > tmfs_pkg::RAW_W) ? FS_W : tmfs_pkg::RAW_W;
    localparam int PROD_W  = VAL_W + tmfs_pkg::DIM_W;
    localparam int SHIFT   = PROD_W + $clog2(FULL_SCALE);
    localparam int RECIP_W = PROD_W + 1;
    localparam int MUL_W   = PROD_W + RECIP_W;
    localparam int QUO_W   = MUL_W - SHIFT;
    localparam logic [63:0] RECIP =
        ((64'd1 << SHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);

    localparam tmfs_pkg::dim_t WIDTH_RST  = 11'd320;
    localparam tmfs_pkg::dim_t HEIGHT_RST = 11'd240;
    localparam tmfs_pkg::raw_t LOWER_RST  = 12'd150;
    localparam tmfs_pkg::raw_t UPPER_RST  = 12'd3900;

    tmfs_pkg::op_t op;
    logic          in_acc;
    logic          en1;
    logic          en2;
    logic          en3;

    tmfs_pkg::dim_t width_reg;
    tmfs_pkg::dim_t height_reg;
    tmfs_pkg::raw_t lower_reg;
    tmfs_pkg::raw_t upper_reg;

    logic [SAMPLE_COUNT-1:0][tmfs_pkg::RAW_W-1:0] x_store_reg;
    logic [SAMPLE_COUNT-1:0][tmfs_pkg::RAW_W-1:0] y_store_reg;
    logic [FILL_W-1:0] x_fill_reg;
    logic [FILL_W-1:0] y_fill_reg;
    tmfs_pkg::raw_t    raw_x_hold_reg;
    tmfs_pkg::raw_t    raw_y_hold_reg;
    tmfs_pkg::raw_t    mx;
    tmfs_pkg::raw_t    my;
    tmfs_pkg::raw_t    xmed_next;
    tmfs_pkg::raw_t    ymed_next;

    logic              s1_valid_reg;
    logic              s1_frame_reg;
    tmfs_pkg::raw_t    s1_xmed_reg;
    tmfs_pkg::raw_t    s1_ymed_reg;

    logic              s2_valid_reg;
    logic              s2_hit_reg;
    logic [PROD_W-1:0] s2_px_reg;
    logic [PROD_W-1:0] s2_py_reg;
    tmfs_pkg::raw_t    s2_xmed_reg;
    tmfs_pkg::raw_t    s2_ymed_reg;

    logic              hit;
    logic [VAL_W-1:0]  y_ext;
    logic [VAL_W-1:0]  y_inv;
    logic [MUL_W-1:0]  qx_full;
    logic [MUL_W-1:0]  qy_full;
    logic [QUO_W-1:0]  qx;
    logic [QUO_W-1:0]  qy;
    tmfs_pkg::pos_t    x_pos_next;
    tmfs_pkg::pos_t    y_pos_next;

    logic              out_valid_reg;
    logic              touched_reg;
    tmfs_pkg::pos_t    x_pos_reg;
    tmfs_pkg::pos_t    y_pos_reg;
    tmfs_pkg::raw_t    x_median_reg;
    tmfs_pkg::raw_t    y_median_reg;

    assign op        = tmfs_pkg::op_t'(opcode);
    assign en3       = !out_valid_reg || !out_stall;
    assign en2       = !s2_valid_reg || en3;
    assign en1       = !s1_valid_reg || en2;
    assign in_stall  = !en1;
    assign in_acc    = in_valid && en1;
    assign cfg_ready = 1'b1;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            lower_reg  <= LOWER_RST;
            upper_reg  <= UPPER_RST;
        end
        else if (cfg_valid)
        begin
            unique case (tmfs_pkg::cfg_idx_t'(cfg_index))
                tmfs_pkg::CFG_SCREEN_WIDTH:  width_reg  <= cfg_data[tmfs_pkg::DIM_W-1:0];
                tmfs_pkg::CFG_SCREEN_HEIGHT: height_reg <= cfg_data[tmfs_pkg::DIM_W-1:0];
                tmfs_pkg::CFG_LOWER_BOUND:   lower_reg  <= cfg_data;
                tmfs_pkg::CFG_UPPER_BOUND:   upper_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    tmfs_median #(
        .COUNT (SAMPLE_COUNT)
    ) u_x_median (
        .store  (x_store_reg),
        .median (mx)
    );

    tmfs_median #(
        .COUNT (SAMPLE_COUNT)
    ) u_y_median (
        .store  (y_store_reg),
        .median (my)
    );

    assign xmed_next = (op == tmfs_pkg::OP_FRAME_END) ? mx : raw_x_hold_reg;
    assign ymed_next = (op == tmfs_pkg::OP_FRAME_END) ? my : raw_y_hold_reg;

    // sample stores, fill counts and raw median holds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_store_reg    <= '0;
            y_store_reg    <= '0;
            x_fill_reg     <= '0;
            y_fill_reg     <= '0;
            raw_x_hold_reg <= '0;
            raw_y_hold_reg <= '0;
        end
        else if (in_acc)
        begin
            unique case (op)
                tmfs_pkg::OP_X_SAMPLE:
                begin
                    if (x_fill_reg < FILL_W'(SAMPLE_COUNT))
                    begin
                        for (int i = 0; i < SAMPLE_COUNT; i++)
                        begin
                            if (x_fill_reg == FILL_W'(i))
                            begin
                                x_store_reg[i] <= sample;
                            end
                        end
                        x_fill_reg <= x_fill_reg + FILL_W'(1);
                    end
                end
                tmfs_pkg::OP_Y_SAMPLE:
                begin
                    if (y_fill_reg < FILL_W'(SAMPLE_COUNT))
                    begin
                        for (int i = 0; i < SAMPLE_COUNT; i++)
                        begin
                            if (y_fill_reg == FILL_W'(i))
                            begin
                                y_store_reg[i] <= sample;
                            end
                        end
                        y_fill_reg <= y_fill_reg + FILL_W'(1);
                    end
                end
                default:
                begin
                    x_fill_reg     <= '0;
                    y_fill_reg     <= '0;
                    raw_x_hold_reg <= xmed_next;
                    raw_y_hold_reg <= ymed_next;
                end
            endcase
        end
    end

    // stage 1: medians captured
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en1)
        begin
            s1_valid_reg <= in_acc && ((op == tmfs_pkg::OP_PEN_UP) ||
                                       (op == tmfs_pkg::OP_FRAME_END));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_frame_reg <= (op == tmfs_pkg::OP_FRAME_END);
            s1_xmed_reg  <= xmed_next;
            s1_ymed_reg  <= ymed_next;
        end
    end

    // stage 2: bounds check, Y inversion, scaling multiply
    assign hit = s1_frame_reg &&
                 (s1_xmed_reg > lower_reg) && (s1_xmed_reg < upper_reg) &&
                 (s1_ymed_reg > lower_reg) && (s1_ymed_reg < upper_reg);
    assign y_ext = VAL_W'(s1_ymed_reg);
    assign y_inv = (y_ext > VAL_W'(FULL_SCALE)) ? '0 : (VAL_W'(FULL_SCALE) - y_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en2)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_hit_reg  <= hit;
            s2_px_reg   <= PROD_W'(s1_xmed_reg) * PROD_W'(width_reg);
            s2_py_reg   <= PROD_W'(y_inv) * PROD_W'(height_reg);
            s2_xmed_reg <= s1_xmed_reg;
            s2_ymed_reg <= s1_ymed_reg;
        end
    end

    // stage 3: divide by full scale via reciprocal, saturate
    assign qx_full = MUL_W'(s2_px_reg) * MUL_W'(RECIP[RECIP_W-1:0]);
    assign qy_full = MUL_W'(s2_py_reg) * MUL_W'(RECIP[RECIP_W-1:0]);
    assign qx      = qx_full[MUL_W-1:SHIFT];
    assign qy      = qy_full[MUL_W-1:SHIFT];
    assign x_pos_next = (qx > QUO_W'(tmfs_pkg::POS_MAX)) ? tmfs_pkg::POS_MAX
                                                          : qx[tmfs_pkg::POS_W-1:0];
    assign y_pos_next = (qy > QUO_W'(tmfs_pkg::POS_MAX)) ? tmfs_pkg::POS_MAX
                                                          : qy[tmfs_pkg::POS_W-1:0];

    // output register; positions and touch flag double as the held values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            touched_reg   <= 1'b0;
            x_pos_reg     <= '0;
            y_pos_reg     <= '0;
        end
        else if (en3)
        begin
            out_valid_reg <= s2_valid_reg;
            if (s2_valid_reg)
            begin
                touched_reg <= s2_hit_reg;
                if (s2_hit_reg)
                begin
                    x_pos_reg <= x_pos_next;
                    y_pos_reg <= y_pos_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && s2_valid_reg)
        begin
            x_median_reg <= s2_xmed_reg;
            y_median_reg <= s2_ymed_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign touched   = touched_reg;
    assign x_pos     = x_pos_reg;
    assign y_pos     = y_pos_reg;
    assign x_median  = x_median_reg;
    assign y_median  = y_median_reg;

endmodule

/* tb/touch_report_checker.sv */
module touch_report_checker
    import tmfs_pkg::*;
#(
    parameter int SAMPLE_COUNT = 5,
    parameter int FULL_SCALE   = 4095
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [1:0]           opcode,
    input  raw_t                 sample,

    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 touched,
    input  pos_t                 x_pos,
    input  pos_t                 y_pos,
    input  raw_t                 x_median,
    input  raw_t                 y_median,

    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  raw_t                 cfg_data,

    output int                   mismatches,
    output int                   reports_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam dim_t WIDTH_RST  = 11'd320;
    localparam dim_t HEIGHT_RST = 11'd240;
    localparam raw_t LOWER_RST  = 12'd150;
    localparam raw_t UPPER_RST  = 12'd3900;

    typedef struct packed {
        logic touched;
        pos_t x_pos;
        pos_t y_pos;
        raw_t x_median;
        raw_t y_median;
    } touch_report_t;

    typedef raw_t sample_bank_t [SAMPLE_COUNT];

    dim_t          width_q;
    dim_t          height_q;
    raw_t          lower_q;
    raw_t          upper_q;
    sample_bank_t  x_bank;
    sample_bank_t  y_bank;
    int unsigned   x_count;
    int unsigned   y_count;
    raw_t          x_med_hold;
    raw_t          y_med_hold;
    pos_t          x_pos_hold;
    pos_t          y_pos_hold;
    logic          touch_hold;
    touch_report_t expected_reports [$];
    int            fail_total = 0;

    assign mismatches = fail_total;

    function automatic raw_t store_median(sample_bank_t bank);
        sample_bank_t s;
        raw_t         t;
        s = bank;
        for (int i = 0; i < SAMPLE_COUNT - 1; i++)
        begin
            for (int j = i + 1; j < SAMPLE_COUNT; j++)
            begin
                if (s[j] < s[i])
                begin
                    t    = s[i];
                    s[i] = s[j];
                    s[j] = t;
                end
            end
        end
        return s[SAMPLE_COUNT / 2];
    endfunction

    function automatic pos_t scale_coord(raw_t v, dim_t size);
        longint unsigned q;
        q = (64'(v) * 64'(size)) / FULL_SCALE;
        return (q > POS_MAX) ? POS_MAX : pos_t'(q);
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fail_total++;
    endtask

    task automatic predict_step(op_t op, raw_t s);
        raw_t mx;
        raw_t my;
        raw_t inv;
        case (op)
            OP_X_SAMPLE:
            begin
                if (x_count < SAMPLE_COUNT)
                begin
                    x_bank[x_count] = s;
                    x_count++;
                end
            end
            OP_Y_SAMPLE:
            begin
                if (y_count < SAMPLE_COUNT)
                begin
                    y_bank[y_count] = s;
                    y_count++;
                end
            end
            default:
            begin
                x_count = 0;
                y_count = 0;
                if (op == OP_PEN_UP)
                begin
                    touch_hold = 1'b0;
                end
                else
                begin
                    mx = store_median(x_bank);
                    my = store_median(y_bank);
                    x_med_hold = mx;
                    y_med_hold = my;
                    if (mx > lower_q && mx < upper_q && my > lower_q && my < upper_q)
                    begin
                        inv        = (my > FULL_SCALE) ? '0 : raw_t'(FULL_SCALE - my);
                        x_pos_hold = scale_coord(mx, width_q);
                        y_pos_hold = scale_coord(inv, height_q);
                        touch_hold = 1'b1;
                    end
                    else
                    begin
                        touch_hold = 1'b0;
                    end
                end
                expected_reports.push_back('{touch_hold, x_pos_hold, y_pos_hold,
                                             x_med_hold, y_med_hold});
            end
        endcase
    endtask

    task automatic check_report(touch_report_t got);
        touch_report_t want;
        if (expected_reports.size() == 0)
        begin
            report_mismatch("result with no transaction pending");
        end
        else
        begin
            want = expected_reports.pop_front();
            if (got.touched !== want.touched)
                report_mismatch($sformatf("touched got %0b want %0b",
                                          got.touched, want.touched));
            if (got.x_pos !== want.x_pos)
                report_mismatch($sformatf("x_pos got %0d want %0d", got.x_pos, want.x_pos));
            if (got.y_pos !== want.y_pos)
                report_mismatch($sformatf("y_pos got %0d want %0d", got.y_pos, want.y_pos));
            if (got.x_median !== want.x_median)
                report_mismatch($sformatf("x_median got %0d want %0d",
                                          got.x_median, want.x_median));
            if (got.y_median !== want.y_median)
                report_mismatch($sformatf("y_median got %0d want %0d",
                                          got.y_median, want.y_median));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_q    = WIDTH_RST;
            height_q   = HEIGHT_RST;
            lower_q    = LOWER_RST;
            upper_q    = UPPER_RST;
            foreach (x_bank[i]) x_bank[i] = '0;
            foreach (y_bank[i]) y_bank[i] = '0;
            x_count    = 0;
            y_count    = 0;
            x_med_hold = '0;
            y_med_hold = '0;
            x_pos_hold = '0;
            y_pos_hold = '0;
            touch_hold = 1'b0;
            expected_reports.delete();
            reports_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_SCREEN_WIDTH:  width_q  = dim_t'(cfg_data);
                    CFG_SCREEN_HEIGHT: height_q = dim_t'(cfg_data);
                    CFG_LOWER_BOUND:   lower_q  = cfg_data;
                    CFG_UPPER_BOUND:   upper_q  = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
                check_report('{touched, x_pos, y_pos, x_median, y_median});
            if (in_valid && !in_stall)
                predict_step(op_t'(opcode), sample);
            reports_pending <= expected_reports.size();
        end
    end

endmodule

/* tb/touch_median_filter_scaler_unit_tb.sv */
module touch_median_filter_scaler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tmfs_pkg::*;

    localparam int SAMPLE_COUNT  = 5;
    localparam int FULL_SCALE    = 4095;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS   = 250;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    op_t        opcode    = OP_PEN_UP;
    raw_t       sample    = '0;
    logic       out_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    cfg_idx_t   cfg_index = CFG_SCREEN_WIDTH;
    raw_t       cfg_data  = '0;

    logic       in_stall;
    logic       out_valid;
    logic       touched;
    pos_t       x_pos;
    pos_t       y_pos;
    raw_t       x_median;
    raw_t       y_median;
    logic       cfg_ready;

    int         mismatches;
    int         reports_pending;

    int         aim_lo = 150;
    int         aim_hi = 3900;
    int         burst_left = 0;
    int         items_sent = 0;
    int         cycle_count = 0;
    int         stall_mode = 0;
    int         stall_run = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    touch_median_filter_scaler_unit #(
        .SAMPLE_COUNT (SAMPLE_COUNT),
        .FULL_SCALE   (FULL_SCALE)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .touched   (touched),
        .x_pos     (x_pos),
        .y_pos     (y_pos),
        .x_median  (x_median),
        .y_median  (y_median),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    touch_report_checker #(
        .SAMPLE_COUNT (SAMPLE_COUNT),
        .FULL_SCALE   (FULL_SCALE)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .sample          (sample),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .touched         (touched),
        .x_pos           (x_pos),
        .y_pos           (y_pos),
        .x_median        (x_median),
        .y_median        (y_median),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .reports_pending (reports_pending)
    );

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver backpressure: modes from free-flowing to heavy stall
    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(20, 200);
        end
        else
        begin
            stall_run--;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    task automatic send_item(op_t op, raw_t s);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                opcode   <= op_t'($urandom_range(0, 3));
                sample   <= raw_t'($urandom);
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        sample   <= s;
        do
            @(posedge clk);
        while (in_stall);
        burst_left--;
        items_sent++;
    endtask

    task automatic drain(int settle);
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (reports_pending != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_reg(cfg_idx_t idx, raw_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic program_regs(raw_t w, raw_t h, raw_t lo, raw_t hi);
        drain(SETTLE_CYCLES);
        write_reg(CFG_SCREEN_WIDTH, w);
        write_reg(CFG_SCREEN_HEIGHT, h);
        write_reg(CFG_LOWER_BOUND, lo);
        write_reg(CFG_UPPER_BOUND, hi);
        cfg_valid <= 1'b0;
        aim_lo = int'(lo);
        aim_hi = int'(hi);
    endtask

    function automatic raw_t pick_sample();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r <= 3)
            return raw_t'($urandom);
        if (r == 4)
            return raw_t'(aim_lo + $urandom_range(0, 2) - 1);
        if (r == 5)
            return raw_t'(aim_hi + $urandom_range(0, 2) - 1);
        if (aim_hi > aim_lo + 1)
            return raw_t'($urandom_range(aim_lo + 1, aim_hi - 1));
        return raw_t'($urandom);
    endfunction

    task automatic run_frame();
        int  nx;
        int  ny;
        op_t fin;
        nx = ($urandom_range(0, 9) < 7) ? SAMPLE_COUNT : $urandom_range(0, SAMPLE_COUNT + 3);
        ny = ($urandom_range(0, 9) < 7) ? SAMPLE_COUNT : $urandom_range(0, SAMPLE_COUNT + 3);
        while (nx > 0 || ny > 0)
        begin
            if (ny == 0 || (nx > 0 && $urandom_range(0, 1)))
            begin
                send_item(OP_X_SAMPLE, pick_sample());
                nx--;
            end
            else
            begin
                send_item(OP_Y_SAMPLE, pick_sample());
                ny--;
            end
        end
        fin = ($urandom_range(0, 6) == 0) ? OP_PEN_UP : OP_FRAME_END;
        send_item(fin, raw_t'($urandom));
    endtask

    task automatic run_phase(int n);
        int target;
        int r;
        target = items_sent + n;
        while (items_sent < target)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_item(op_t'($urandom_range(0, 3)), raw_t'($urandom));
            end
            else if (r == 1)
            begin
                drain(0);
            end
            else
            begin
                run_frame();
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pen up and empty frame straight out of reset
        send_item(OP_PEN_UP, 12'd0);
        send_item(OP_FRAME_END, 12'hFFF);
        // full frame with field extremes, one extra X past a full store
        send_item(OP_X_SAMPLE, 12'd0);
        send_item(OP_Y_SAMPLE, 12'hFFF);
        send_item(OP_X_SAMPLE, 12'hFFF);
        send_item(OP_Y_SAMPLE, 12'd0);
        send_item(OP_X_SAMPLE, 12'd2000);
        send_item(OP_Y_SAMPLE, 12'd1000);
        send_item(OP_X_SAMPLE, 12'd2001);
        send_item(OP_Y_SAMPLE, 12'd1001);
        send_item(OP_X_SAMPLE, 12'd1999);
        send_item(OP_Y_SAMPLE, 12'd999);
        send_item(OP_X_SAMPLE, 12'd3000);
        send_item(OP_FRAME_END, 12'd0);
        // short frame: old store entries take part in the median
        send_item(OP_X_SAMPLE, 12'hFFF);
        send_item(OP_X_SAMPLE, 12'hFFF);
        send_item(OP_X_SAMPLE, 12'hFFF);
        send_item(OP_FRAME_END, 12'd5);
        send_item(OP_Y_SAMPLE, 12'd2048);
        send_item(OP_PEN_UP, 12'hAAA);
        send_item(OP_FRAME_END, 12'h555);

        run_phase(PHASE_ITEMS);
        program_regs(12'd1, 12'd1, 12'd0, 12'd4095);
        run_phase(PHASE_ITEMS);
        program_regs(12'd1024, 12'd1024, 12'd150, 12'd3900);
        run_phase(PHASE_ITEMS);
        // width bit 11 is dropped, leaving 2047: scaled coordinates saturate
        program_regs(12'hFFF, 12'd2047, 12'd0, 12'd4095);
        run_phase(PHASE_ITEMS);
        program_regs(12'd640, 12'd480, 12'd2000, 12'd2100);
        run_phase(PHASE_ITEMS);
        program_regs(12'd1000, 12'd3, 12'd4095, 12'd0);
        run_phase(PHASE_ITEMS / 2);
        program_regs(raw_t'($urandom_range(1, 1024)), raw_t'($urandom_range(1, 1024)),
                     raw_t'($urandom_range(0, 1000)), raw_t'($urandom_range(3000, 4095)));
        run_phase(PHASE_ITEMS);

        drain(SETTLE_CYCLES);
        if (mismatches == 0 && reports_pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/core/tmfs_pkg.sv
rtl/core/tmfs_median.sv
rtl/core/touch_median_filter_scaler_unit.sv
tb/touch_report_checker.sv
tb/touch_median_filter_scaler_unit_tb.sv
